// ----- hdl/sbba_pkg.sv -----
package sbba_pkg;

   // map word geometry
   localparam int WORD_BITS = 64;
   localparam int POS_W     = 6;

   // field widths
   localparam int ADDR_W     = 48;
   localparam int CNT_IN_W   = 11;
   localparam int BYTES_W    = 19;
   localparam int TOTAL_W    = 32;
   localparam int IDX_OUT_W  = 10;
   localparam int STATUS_W   = 2;
   localparam int RSP_PACK_W = STATUS_W + ADDR_W + IDX_OUT_W + 2 * BYTES_W + 2 * TOTAL_W;
   localparam int RSP_W      = ((RSP_PACK_W + 7) / 8) * 8;

   // pool geometry
   localparam int BLOCK_BYTES    = 256;
   localparam int BLOCK_SHIFT    = $clog2(BLOCK_BYTES);
   localparam int MAX_BLOCKS_DEF = 1024;

   localparam logic [BYTES_W-1:0]  BYTES_MAX    = '1;
   localparam logic [CNT_IN_W-1:0] BLOCKS_RESET = 11'd1024;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_FREE     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_OUT_OF_POOL = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_ALLOC   = 2'd3;

   // request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // register indexes
   localparam logic CSR_POOL_BASE = 1'b0;
   localparam logic CSR_BLOCKS    = 1'b1;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] pos;
   } first_free_type;

   // lowest set bit of a word of candidate bits
   function automatic first_free_type find_first_free(input logic [WORD_BITS-1:0] avail);
      first_free_type r;
      r.found = |avail;
      r.pos   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (avail[i]) begin
            r.pos = POS_W'(i);
         end
      end
      return r;
   endfunction

endpackage

// ----- hdl/sbba_map_ram.sv -----
// used-bit map storage: one write port, one registered read port
module sbba_map_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [AW-1:0]                  wr_addr,
   input  logic [sbba_pkg::WORD_BITS-1:0] wr_data,
   input  logic [AW-1:0]                  rd_addr,
   output logic [sbba_pkg::WORD_BITS-1:0] rd_data
);

   logic [sbba_pkg::WORD_BITS-1:0] mem_ff [DEPTH];
   logic [sbba_pkg::WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/small_block_bitmap_allocator_unit.sv -----
// Small-block allocator over a used-bit map, first fit.
// Request channel (req_*): one transfer is one operation. req_tuser[0] selects
// allocate (0) or free (1); req_tdata holds the byte address to free.
// Response channel (rsp_*): exactly one transfer per request, in order, with
// status, block address and index, and the running byte and operation counts.
// Config port (csr_*): index 0 pool base, index 1 managed block count; write
// only while no request is in flight.
// Steps: an allocate transfer reads map word 0, S_ACHK scans 1 to MAP_WORDS
// map words (16 at the default size), then S_FINISH loads the response; a free
// passes S_FRANGE, S_FCHK and S_FINISH, skipping S_FCHK when the address is
// outside the pool, and the next request is taken in S_IDLE.
// The map word scan, one 64-bit word per cycle through the single read port
// of the map RAM, sets the allocate time. One request is in flight at a time;
// req_tready is high again the cycle after the response is loaded.
// A finished response waits in the output register; if the receiver stalls,
// the block holds the next result until the register empties.
// Reset (synchronous): counts and registers return to defaults, then a
// clearing pass zeroes the map, one word per cycle, with req_tready low.
// Config writes are taken during the pass.
module small_block_bitmap_allocator_unit #(
   parameter int MAX_BLOCKS = sbba_pkg::MAX_BLOCKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sbba_pkg::ADDR_W-1:0]     req_tdata,  // [47:0] free_address
   input  logic [0:0]                      req_tuser,  // [0] kind
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [1:0] status, [49:2] block_address, [59:50] block_index,
   // [78:60] used_bytes, [97:79] peak_bytes, [129:98] alloc_total,
   // [161:130] free_total, [167:162] zero
   output logic [sbba_pkg::RSP_W-1:0]      rsp_tdata,
   // configuration write port
   input  logic                            csr_we,
   input  logic [0:0]                      csr_index,
   input  logic [sbba_pkg::ADDR_W-1:0]     csr_wdata
);

   localparam int WB        = sbba_pkg::WORD_BITS;
   localparam int PW        = sbba_pkg::POS_W;
   localparam int AW        = sbba_pkg::ADDR_W;
   localparam int BW        = sbba_pkg::BYTES_W;
   localparam int TW        = sbba_pkg::TOTAL_W;
   localparam int MAP_WORDS = (MAX_BLOCKS + WB - 1) / WB;
   localparam int IDX_W     = ($clog2(MAX_BLOCKS) < PW + 1) ? PW + 1 : $clog2(MAX_BLOCKS);
   localparam int WA_W      = IDX_W - PW;
   localparam int NB_W      = ($clog2(MAX_BLOCKS + 1) > sbba_pkg::CNT_IN_W) ?
                              $clog2(MAX_BLOCKS + 1) : sbba_pkg::CNT_IN_W;
   localparam int CW        = ((NB_W > IDX_W) ? NB_W : IDX_W) + 1;

   // sequencer states
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_ACHK   = 3'd2;
   localparam logic [2:0] S_FRANGE = 3'd3;
   localparam logic [2:0] S_FCHK   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic [WA_W-1:0]               clr_ff, clr_in;
   logic [WA_W-1:0]               ptr_ff, ptr_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [AW-1:0]                 off_ff, off_in;
   logic                          kind_ff, kind_in;
   logic [sbba_pkg::STATUS_W-1:0] status_ff, status_in;

   logic [AW-1:0]                 pool_base_ff;
   logic [sbba_pkg::CNT_IN_W-1:0] blocks_ff;

   logic [BW-1:0]                 used_ff, used_in;
   logic [BW-1:0]                 peak_ff, peak_in;
   logic [TW-1:0]                 alloc_cnt_ff, alloc_cnt_in;
   logic [TW-1:0]                 free_cnt_ff, free_cnt_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sbba_pkg::RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   // map RAM port signals
   logic                          map_wr_en;
   logic [WA_W-1:0]               map_wr_addr;
   logic [WB-1:0]                 map_wr_data;
   logic [WA_W-1:0]               map_rd_addr;
   logic [WB-1:0]                 map_rd_data;

   // shared compare and scan logic
   logic [NB_W-1:0]               blocks_ext;
   logic [NB_W-1:0]               n_act;
   logic [CW-1:0]                 n_c, base_c, rem_c;
   logic [WB-1:0]                 word_mask;
   logic                          last_word;
   sbba_pkg::first_free_type      ff;
   logic [AW-1:0]                 span;
   logic                          out_of_pool;
   logic [IDX_W-1:0]              free_blk;
   logic [BW:0]                   used_sum;
   logic [BW-1:0]                 used_sat, used_dec;
   logic [AW-1:0]                 blk_addr;
   logic                          op_ok;
   logic                          req_xfer;
   logic                          out_free;

   sbba_map_ram #(
      .DEPTH (MAP_WORDS),
      .AW    (WA_W)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   // count above capacity clamps to capacity
   assign blocks_ext = NB_W'(blocks_ff);
   assign n_act      = (blocks_ext > NB_W'(MAX_BLOCKS)) ? NB_W'(MAX_BLOCKS) : blocks_ext;

   // valid bits of the scanned word: block index below the active count
   assign n_c    = CW'(n_act);
   assign base_c = CW'({ptr_ff, PW'(0)});
   assign rem_c  = n_c - base_c;

   always_comb begin
      priority if (n_c <= base_c) begin
         word_mask = '0;
      end else if (rem_c >= CW'(WB)) begin
         word_mask = '1;
      end else begin
         word_mask = ~({WB{1'b1}} << rem_c[PW-1:0]);
      end
   end

   assign last_word = (n_c <= base_c + CW'(WB));
   assign ff        = sbba_pkg::find_first_free(~map_rd_data & word_mask);

   // pool range test on the offset held from the request cycle
   assign span        = AW'(n_act) << sbba_pkg::BLOCK_SHIFT;
   assign out_of_pool = (off_ff >= span);
   assign free_blk    = off_ff[sbba_pkg::BLOCK_SHIFT +: IDX_W];

   // byte count update, saturating up, floored at zero down
   assign used_sum = {1'b0, used_ff} + (BW + 1)'(sbba_pkg::BLOCK_BYTES);
   assign used_sat = (used_sum > (BW + 1)'(sbba_pkg::BYTES_MAX)) ?
                     sbba_pkg::BYTES_MAX : used_sum[BW-1:0];
   assign used_dec = (used_ff >= BW'(sbba_pkg::BLOCK_BYTES)) ?
                     used_ff - BW'(sbba_pkg::BLOCK_BYTES) : '0;

   assign blk_addr = pool_base_ff + (AW'(idx_ff) << sbba_pkg::BLOCK_SHIFT);
   assign op_ok    = (status_ff == sbba_pkg::STAT_OK);

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      ptr_in       = ptr_ff;
      idx_in       = idx_ff;
      off_in       = off_ff;
      kind_in      = kind_ff;
      status_in    = status_ff;
      used_in      = used_ff;
      peak_in      = peak_ff;
      alloc_cnt_in = alloc_cnt_ff;
      free_cnt_in  = free_cnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      map_wr_en    = 1'b0;
      map_wr_addr  = ptr_ff;
      map_wr_data  = '0;
      map_rd_addr  = '0;

      unique case (state_ff)
         S_CLEAR: begin
            map_wr_en   = 1'b1;
            map_wr_addr = clr_ff;
            if (clr_ff == WA_W'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            // word 0 is read on the transfer edge for an allocate scan
            if (req_xfer) begin
               kind_in  = req_tuser[0];
               ptr_in   = '0;
               off_in   = req_tdata - pool_base_ff;
               state_in = (req_tuser[0] == sbba_pkg::KIND_ALLOC) ? S_ACHK : S_FRANGE;
            end
         end
         S_ACHK: begin
            priority if (ff.found) begin
               map_wr_en   = 1'b1;
               map_wr_addr = ptr_ff;
               map_wr_data = map_rd_data | (WB'(1) << ff.pos);
               idx_in      = {ptr_ff, ff.pos};
               status_in   = sbba_pkg::STAT_OK;
               state_in    = S_FINISH;
            end else if (last_word) begin
               status_in = sbba_pkg::STAT_NO_FREE;
               state_in  = S_FINISH;
            end else begin
               ptr_in      = ptr_ff + 1'b1;
               map_rd_addr = ptr_ff + 1'b1;
            end
         end
         S_FRANGE: begin
            if (out_of_pool) begin
               status_in = sbba_pkg::STAT_OUT_OF_POOL;
               state_in  = S_FINISH;
            end else begin
               idx_in      = free_blk;
               map_rd_addr = free_blk[IDX_W-1:PW];
               state_in    = S_FCHK;
            end
         end
         S_FCHK: begin
            if (map_rd_data[idx_ff[PW-1:0]]) begin
               map_wr_en   = 1'b1;
               map_wr_addr = idx_ff[IDX_W-1:PW];
               map_wr_data = map_rd_data & ~(WB'(1) << idx_ff[PW-1:0]);
               status_in   = sbba_pkg::STAT_OK;
            end else begin
               status_in = sbba_pkg::STAT_NOT_ALLOC;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold here while the previous response is still waiting
            if (out_free) begin
               if (op_ok && kind_ff == sbba_pkg::KIND_ALLOC) begin
                  used_in      = used_sat;
                  peak_in      = (used_sat > peak_ff) ? used_sat : peak_ff;
                  alloc_cnt_in = alloc_cnt_ff + 1'b1;
               end else if (op_ok) begin
                  used_in     = used_dec;
                  free_cnt_in = free_cnt_ff + 1'b1;
               end
               rsp_data_in = {
                  {(sbba_pkg::RSP_W - sbba_pkg::RSP_PACK_W){1'b0}},
                  free_cnt_in,
                  alloc_cnt_in,
                  peak_in,
                  used_in,
                  op_ok ? sbba_pkg::IDX_OUT_W'(idx_ff) : {sbba_pkg::IDX_OUT_W{1'b0}},
                  op_ok ? blk_addr : {AW{1'b0}},
                  status_ff
               };
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         peak_ff      <= '0;
         alloc_cnt_ff <= '0;
         free_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         pool_base_ff <= '0;
         blocks_ff    <= sbba_pkg::BLOCKS_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         peak_ff      <= peak_in;
         alloc_cnt_ff <= alloc_cnt_in;
         free_cnt_ff  <= free_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index[0] == sbba_pkg::CSR_POOL_BASE) begin
            pool_base_ff <= csr_wdata;
         end
         if (csr_we && csr_index[0] == sbba_pkg::CSR_BLOCKS) begin
            blocks_ff <= csr_wdata[sbba_pkg::CNT_IN_W-1:0];
         end
      end
      ptr_ff      <= ptr_in;
      idx_ff      <= idx_in;
      off_ff      <= off_in;
      kind_ff     <= kind_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   // map is only written by the clearing pass or by a hit in a check state
   a_map_write_state: assert property (@(posedge clock) disable iff (reset)
      map_wr_en |-> (state_ff == S_CLEAR || state_ff == S_ACHK || state_ff == S_FCHK))
      else $error("map written outside clear or check state");

   // scan never runs past the last map word
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACHK) |-> (ptr_ff <= WA_W'(MAP_WORDS - 1)))
      else $error("scan pointer beyond map");

   // a failed operation reports no block
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[1:0] != sbba_pkg::STAT_OK) |->
      (rsp_data_ff[59:2] == '0))
      else $error("failure response carries a block");

   // peak never falls below the current byte count
   a_peak_bound: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= used_ff)
      else $error("peak below used bytes");

   // an accepted request always leaves idle
   a_req_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == S_ACHK || state_ff == S_FRANGE))
      else $error("request transfer did not start an operation");
`endif

endmodule
